// ===== hw/rtl/bse_pkg.sv =====
// bse_pkg: shared types, codes and tables of the bech32 string encoder
// holds the queue command type, the polymod step and the alphabet lookup
// no dependencies
package bse_pkg;

   localparam int CNT_W = 7;
   localparam int QUEUE_DEPTH = 4;

   // input action codes
   localparam logic [1:0] ACT_PREFIX = 2'd0;
   localparam logic [1:0] ACT_SYMBOL = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG   = 2'd2;
   localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd3;

   // queue command codes
   localparam logic [1:0] OP_PREFIX = 2'd0;
   localparam logic [1:0] OP_SYMBOL = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_ERROR  = 2'd3;

   localparam logic [7:0] CHAR_MIN = 8'd33;
   localparam logic [7:0] CHAR_MAX = 8'd126;
   localparam logic [7:0] UPPER_A  = 8'h41;
   localparam logic [7:0] UPPER_Z  = 8'h5a;
   localparam logic [7:0] SYM_MAX  = 8'd31;
   localparam logic [7:0] CHECK_LEN = 8'd6;
   localparam logic [6:0] SEP_CHAR = 7'h31;

   localparam logic [29:0] ACC_INIT = 30'd1;
   localparam logic [29:0] GEN0 = 30'h3b6a57b2;
   localparam logic [29:0] GEN1 = 30'h26508e6d;
   localparam logic [29:0] GEN2 = 30'h1ea119fa;
   localparam logic [29:0] GEN3 = 30'h3d4233dd;
   localparam logic [29:0] GEN4 = 30'h2a1462b3;

   localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef struct packed {
      logic [1:0] op;
      logic       open;
      logic [7:0] value;
      logic [1:0] status;
   } cmd_type;

   function automatic logic [29:0] poly_step(input logic [29:0] acc);
      logic [4:0]  top;
      logic [29:0] r;
      top = acc[29:25];
      r = {acc[24:0], 5'd0};
      if (top[0]) r = r ^ GEN0;
      if (top[1]) r = r ^ GEN1;
      if (top[2]) r = r ^ GEN2;
      if (top[3]) r = r ^ GEN3;
      if (top[4]) r = r ^ GEN4;
      return r;
   endfunction

   function automatic logic [6:0] letter(input logic [4:0] sym);
      return ALPHABET[8*(31 - int'(sym)) +: 7];
   endfunction

endpackage

// ===== hw/rtl/bse_req_if.sv =====
// bse_req_if: request channel of the bech32 string encoder
// valid/ready handshake with action and value payload, no dependencies
interface bse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

// ===== hw/rtl/bse_rsp_if.sv =====
// bse_rsp_if: response channel of the bech32 string encoder
// valid/ready handshake with char_code, status and last, no dependencies
interface bse_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output char_code, output status, output last, input ready);
   modport sink (input valid, input char_code, input status, input last, output ready);
endinterface

// ===== hw/rtl/bse_front.sv =====
// bse_front: accepts request beats, checks the string rules, issues commands
// depends on bse_pkg and bse_req_if
module bse_front #(
   parameter int PREFIX_MAX = 83,
   parameter int TOTAL_MAX  = 90
) (
   input  logic             clock,
   input  logic             reset,
   bse_req_if.sink          req_ch,
   input  logic             q_full,
   output logic             push_valid,
   output bse_pkg::cmd_type push_cmd
);
   import bse_pkg::*;

   localparam int LEN_W = $clog2(PREFIX_MAX + 1);
   localparam logic [7:0] TOTAL_LIM = 8'(TOTAL_MAX);

   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_ERROR  = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [CNT_W-1:0] scount_ff, scount_in;

   logic       accept;
   logic       bad_char;
   logic       prefix_long;
   logic       symbol_long;
   logic [7:0] plen_ext;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && req_ch.ready;
   assign plen_ext = 8'(plen_ff);

   assign bad_char = (req_ch.value < CHAR_MIN) || (req_ch.value > CHAR_MAX) ||
                     ((req_ch.value >= UPPER_A) && (req_ch.value <= UPPER_Z));
   assign prefix_long = (plen_ff >= LEN_W'(PREFIX_MAX)) ||
                        ((plen_ext + 8'd8) > TOTAL_LIM);
   assign symbol_long = (plen_ext + 8'd8 + 8'(scount_ff)) > TOTAL_LIM;

   always_comb begin
      phase_in = phase_ff;
      plen_in = plen_ff;
      scount_in = scount_ff;
      push_valid = 1'b0;
      push_cmd.op = OP_ERROR;
      push_cmd.open = 1'b0;
      push_cmd.value = req_ch.value;
      push_cmd.status = STATUS_OK;
      if (accept) begin
         if (phase_ff == PH_ERROR) begin
            if (req_ch.action == ACT_FINISH) begin
               phase_in = PH_PREFIX;
               plen_in = '0;
               scount_in = '0;
            end
         end else begin
            unique case (req_ch.action)
               ACT_PREFIX: begin
                  push_valid = 1'b1;
                  priority if (phase_ff != PH_PREFIX || bad_char) begin
                     push_cmd.status = STATUS_BAD_CHAR;
                     phase_in = PH_ERROR;
                  end else if (prefix_long) begin
                     push_cmd.status = STATUS_TOO_LONG;
                     phase_in = PH_ERROR;
                  end else begin
                     push_cmd.op = OP_PREFIX;
                     plen_in = plen_ff + 1'b1;
                  end
               end
               ACT_SYMBOL: begin
                  push_valid = 1'b1;
                  priority if (req_ch.value > SYM_MAX) begin
                     push_cmd.status = STATUS_BAD_SYMBOL;
                     phase_in = PH_ERROR;
                  end else if (symbol_long) begin
                     push_cmd.status = STATUS_TOO_LONG;
                     phase_in = PH_ERROR;
                  end else begin
                     push_cmd.op = OP_SYMBOL;
                     push_cmd.open = (phase_ff == PH_PREFIX);
                     phase_in = PH_DATA;
                     scount_in = scount_ff + 1'b1;
                  end
               end
               ACT_FINISH: begin
                  push_valid = 1'b1;
                  push_cmd.op = OP_FINISH;
                  push_cmd.open = (phase_ff == PH_PREFIX);
                  phase_in = PH_PREFIX;
                  plen_in = '0;
                  scount_in = '0;
               end
               ACT_NONE: begin
                  push_valid = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         plen_ff <= '0;
         scount_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         plen_ff <= plen_in;
         scount_ff <= scount_in;
      end
   end

endmodule

// ===== hw/rtl/bse_queue.sv =====
// bse_queue: short command queue between the front and the back
// depends on bse_pkg
module bse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  bse_pkg::cmd_type push_cmd,
   output logic             q_full,
   input  logic             q_pop,
   output logic             q_valid,
   output bse_pkg::cmd_type q_cmd
);
   import bse_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/bse_back.sv =====
// bse_back: runs queued commands, keeps the polymod and the stored prefix bits
// drives the response register; depends on bse_pkg and bse_rsp_if
module bse_back #(
   parameter int PREFIX_MAX = 83
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bse_pkg::cmd_type q_cmd,
   output logic             q_pop,
   bse_rsp_if.source        rsp_ch
);
   import bse_pkg::*;

   localparam int LEN_W = $clog2(PREFIX_MAX + 1);
   localparam int IDX_W = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_REPLAY = 3'd2;
   localparam logic [2:0] S_SEP    = 3'd3;
   localparam logic [2:0] S_SYM    = 3'd4;
   localparam logic [2:0] S_CHK    = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   localparam logic [2:0] CNT_LAST = 3'(CHECK_LEN - 8'd1);

   logic [4:0] prefix_mem [PREFIX_MAX];
   logic [4:0] rd_data_ff;

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [29:0]      acc_ff, acc_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [2:0]       cnt_ff, cnt_in;

   logic             out_vld_ff;
   logic [6:0]       out_char_ff;
   logic [1:0]       out_status_ff;
   logic             out_last_ff;

   logic             can_emit;
   logic             emit;
   logic [6:0]       emit_char;
   logic [1:0]       emit_status;
   logic             emit_last;
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;

   assign can_emit = !out_vld_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      acc_in = acc_ff;
      plen_in = plen_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      emit_char = '0;
      emit_status = STATUS_OK;
      emit_last = 1'b0;
      mem_we = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cmd_in = q_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff.op)
               OP_PREFIX: begin
                  if (can_emit) begin
                     emit = 1'b1;
                     emit_char = cmd_ff.value[6:0];
                     acc_in = poly_step(acc_ff) ^ {27'd0, cmd_ff.value[7:5]};
                     mem_we = 1'b1;
                     plen_in = plen_ff + 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_ERROR: begin
                  if (can_emit) begin
                     emit = 1'b1;
                     emit_status = cmd_ff.status;
                     emit_last = 1'b1;
                     acc_in = ACC_INIT;
                     plen_in = '0;
                     state_in = S_IDLE;
                  end
               end
               OP_SYMBOL, OP_FINISH: begin
                  cnt_in = '0;
                  priority if (cmd_ff.open) begin
                     // separator step, then replay stored low bits
                     acc_in = poly_step(acc_ff);
                     idx_in = '0;
                     state_in = (plen_ff == '0) ? S_SEP : S_REPLAY;
                  end else if (cmd_ff.op == OP_SYMBOL) begin
                     state_in = S_SYM;
                  end else begin
                     state_in = S_CHK;
                  end
               end
            endcase
         end
         S_REPLAY: begin
            acc_in = poly_step(acc_ff) ^ {25'd0, rd_data_ff};
            idx_in = idx_ff + 1'b1;
            rd_addr = idx_in[IDX_W-1:0];
            if (idx_in == plen_ff) state_in = S_SEP;
         end
         S_SEP: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_char = SEP_CHAR;
               cnt_in = '0;
               state_in = (cmd_ff.op == OP_SYMBOL) ? S_SYM : S_CHK;
            end
         end
         S_SYM: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_char = letter(cmd_ff.value[4:0]);
               acc_in = poly_step(acc_ff) ^ {25'd0, cmd_ff.value[4:0]};
               state_in = S_IDLE;
            end
         end
         S_CHK: begin
            acc_in = poly_step(acc_ff) ^ ((cnt_ff == CNT_LAST) ? ACC_INIT : 30'd0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_char = letter(acc_ff[29:25]);
               emit_last = (cnt_ff == CNT_LAST);
               acc_in = {acc_ff[24:0], 5'd0};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  acc_in = ACC_INIT;
                  plen_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) prefix_mem[plen_ff[IDX_W-1:0]] <= cmd_ff.value[4:0];
      rd_data_ff <= prefix_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (emit) begin
         out_char_ff <= emit_char;
         out_status_ff <= emit_status;
         out_last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         acc_ff <= ACC_INIT;
         plen_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         plen_ff <= plen_in;
         out_vld_ff <= emit || (out_vld_ff && !rsp_ch.ready);
      end
   end

   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.char_code = out_char_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.last = out_last_ff;

endmodule

// ===== hw/rtl/bech32_string_encoder.sv =====
// bech32_string_encoder: top level, front checker, command queue and back engine
// depends on bse_pkg, bse_req_if, bse_rsp_if, bse_front, bse_queue, bse_back
//
// req_ch carries one beat per item: action (prefix char, data symbol, finish)
// and value. rsp_ch carries one beat per emitted character: char_code, status
// and last. A string is sent as prefix chars, data symbols, then finish; the
// response is the echoed prefix, the '1' separator, the data letters and six
// checksum letters, last set on the final one. A broken rule gives a single
// beat with nonzero status and last set; input is then dropped until finish.
// The front takes a beat whenever the four-entry command queue has room, so
// requests keep flowing while the back works. The back runs one command at
// a time: a prefix char passes idle and exec, a data symbol idle, exec and
// sym; the first symbol (or finish) also replays the stored prefix bits and
// emits the separator, and finish runs six checksum steps, then six letters;
// the single polymod register and one-read-port prefix memory serialise this.
// A response register sits at the output: when rsp_ch stalls, the back holds
// and the queue fills, then req_ch.ready drops. Synchronous reset clears the
// queue, the phase and the checksum; no clearing pass is needed.
module bech32_string_encoder #(
   parameter int PREFIX_MAX = 83,
   parameter int TOTAL_MAX  = 90
) (
   input  logic      clock,
   input  logic      reset,
   bse_req_if.sink   req_ch,
   bse_rsp_if.source rsp_ch
);
   import bse_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   bse_front #(
      .PREFIX_MAX(PREFIX_MAX),
      .TOTAL_MAX(TOTAL_MAX)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .q_full(q_full),
      .push_valid(push_valid),
      .push_cmd(push_cmd)
   );

   bse_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .q_full(q_full),
      .q_pop(q_pop),
      .q_valid(q_valid),
      .q_cmd(q_cmd)
   );

   bse_back #(
      .PREFIX_MAX(PREFIX_MAX)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .rsp_ch(rsp_ch)
   );

endmodule

// ===== hw/rtl/bse_checker.sv =====
// bse_checker: port-level assertions for the bech32 string encoder
// depends on bse_pkg; bound to bech32_string_encoder at the end of this file
module bse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char_code,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import bse_pkg::*;

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) &&
      $stable(rsp_status) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // error beat closes the string and carries no character
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_char_code == 7'd0)
      else $error("error beat malformed");

   // ok beats are printable characters
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
      {1'b0, rsp_char_code} >= CHAR_MIN && {1'b0, rsp_char_code} <= CHAR_MAX)
      else $error("ok beat not printable");

   // reset empties the output and the queue
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the channels");

endmodule

bind bech32_string_encoder bse_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_char_code(rsp_ch.char_code),
   .rsp_status(rsp_ch.status),
   .rsp_last(rsp_ch.last)
);

// ===== sim/bech32_string_encoder_test.sv =====
// bech32_string_encoder_test: self-checking bench for the bech32 string encoder
// drives prefix, symbol and finish beats with random gaps and stalls and checks
// every response beat against an in-bench encoder; needs bse_pkg and both channel interfaces
module bech32_string_encoder_test;
   import bse_pkg::*;

   localparam int PREFIX_LIMIT = 83;
   localparam int TOTAL_LIMIT = 90;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 150;
   localparam int CALM_TAIL = 40;
   localparam logic [255:0] LETTERS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef enum logic [1:0] {PH_PREFIX, PH_DATA, PH_ERROR} str_phase_e;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } req_item_t;

   typedef struct packed {
      logic [6:0] char_code;
      logic [1:0] status;
      logic       last;
   } char_beat_t;

   logic clock;
   logic reset;

   bse_req_if req_if ();
   bse_rsp_if rsp_if ();

   bech32_string_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   req_item_t  pending[$];
   char_beat_t expected_chars[$];

   logic [4:0]  name_bits [PREFIX_LIMIT];
   logic [29:0] check_acc;
   int unsigned name_len;
   int unsigned sym_count;
   str_phase_e  str_phase;

   int errors = 0;
   int beats_checked = 0;
   int items_queued = 0;
   int strings_queued = 0;
   int send_gap = 0;
   int stall_left = 0;
   int cycle_count = 0;

   always #1 clock = ~clock;

   // encoder state and prediction

   function automatic logic [29:0] bch_step(logic [29:0] acc);
      return {acc[24:0], 5'b0} ^ ({30{acc[25]}} & GEN0) ^ ({30{acc[26]}} & GEN1)
         ^ ({30{acc[27]}} & GEN2) ^ ({30{acc[28]}} & GEN3) ^ ({30{acc[29]}} & GEN4);
   endfunction

   function automatic logic [6:0] letter_of(logic [4:0] sym);
      return LETTERS[254 - 8 * int'(sym) -: 7];
   endfunction

   function automatic void emit(logic [6:0] ch, logic [1:0] st, logic lst);
      char_beat_t b;
      b.char_code = ch;
      b.status = st;
      b.last = lst;
      expected_chars.push_back(b);
   endfunction

   function automatic void clear_string();
      check_acc = ACC_INIT;
      name_len = 0;
      sym_count = 0;
      str_phase = PH_PREFIX;
   endfunction

   function automatic void reject(logic [1:0] st);
      str_phase = PH_ERROR;
      emit(7'd0, st, 1'b1);
   endfunction

   function automatic void open_data();
      check_acc = bch_step(check_acc);
      for (int i = 0; i < name_len; i++)
         check_acc = bch_step(check_acc) ^ {25'd0, name_bits[i]};
      emit(SEP_CHAR, STATUS_OK, 1'b0);
      str_phase = PH_DATA;
   endfunction

   function automatic void encode_item(logic [1:0] act, logic [7:0] val);
      if (act == ACT_NONE) return;
      if (str_phase == PH_ERROR) begin
         if (act == ACT_FINISH) clear_string();
         return;
      end
      case (act)
         ACT_PREFIX: begin
            if (str_phase != PH_PREFIX) reject(STATUS_BAD_CHAR);
            else if (val < CHAR_MIN || val > CHAR_MAX || (val >= UPPER_A && val <= UPPER_Z))
               reject(STATUS_BAD_CHAR);
            else if (name_len >= PREFIX_LIMIT || name_len + 8 > TOTAL_LIMIT)
               reject(STATUS_TOO_LONG);
            else begin
               check_acc = bch_step(check_acc) ^ {27'd0, val[7:5]};
               name_bits[name_len] = val[4:0];
               name_len++;
               emit(val[6:0], STATUS_OK, 1'b0);
            end
         end
         ACT_SYMBOL: begin
            if (val > SYM_MAX) reject(STATUS_BAD_SYMBOL);
            else if (name_len + 7 + sym_count + 1 > TOTAL_LIMIT) reject(STATUS_TOO_LONG);
            else begin
               if (str_phase == PH_PREFIX) open_data();
               check_acc = bch_step(check_acc) ^ {25'd0, val[4:0]};
               sym_count++;
               emit(letter_of(val[4:0]), STATUS_OK, 1'b0);
            end
         end
         default: begin
            if (str_phase == PH_PREFIX) open_data();
            for (int i = 0; i < 6; i++) check_acc = bch_step(check_acc);
            check_acc = check_acc ^ 30'd1;
            for (int i = 0; i < 6; i++)
               emit(letter_of(check_acc[(5 - i) * 5 +: 5]), STATUS_OK, i == 5);
            clear_string();
         end
      endcase
   endfunction

   // stimulus helpers

   function automatic void add_item(logic [1:0] act, logic [7:0] val);
      req_item_t it;
      it.action = act;
      it.value = val;
      pending.push_back(it);
      items_queued++;
      if (act == ACT_FINISH) strings_queued++;
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] c;
      c = 8'($urandom_range(CHAR_MIN, CHAR_MAX));
      if (c >= UPPER_A && c <= UPPER_Z) c = c + 8'd32;
      return c;
   endfunction

   function automatic void add_noise();
      add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endfunction

   // driver

   always @(posedge clock) begin
      req_item_t it;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.action <= ACT_NONE;
         req_if.value <= 8'd0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending.size() > 0) begin
            it = pending.pop_front();
            req_if.valid <= 1'b1;
            req_if.action <= it.action;
            req_if.value <= it.value;
            if (pending.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 6);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted request beats, checks response beats

   always @(posedge clock) begin
      char_beat_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) encode_item(req_if.action, req_if.value);
         if (rsp_if.valid && rsp_if.ready) begin
            beats_checked++;
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat char %h status %0d last %b", $time,
                  rsp_if.char_code, rsp_if.status, rsp_if.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.char_code !== want.char_code) begin
                  errors++;
                  $display("%0t: char_code expected %h actual %h", $time,
                     want.char_code, rsp_if.char_code);
               end
               if (rsp_if.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_if.status);
               end
               if (rsp_if.last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_if.last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int n_pre;
      int n_sym;
      int noise_at;
      int short_items;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACT_NONE;
      req_if.value = 8'd0;
      rsp_if.ready = 1'b0;
      clear_string();

      // directed: empty prefix, field extremes, each bad-char and bad-symbol path
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, CHAR_MIN);
      add_item(ACT_PREFIX, CHAR_MAX);
      add_item(ACT_PREFIX, 8'h61);
      add_item(ACT_SYMBOL, 8'd0);
      add_item(ACT_SYMBOL, SYM_MAX);
      add_item(ACT_FINISH, 8'hff);
      add_item(ACT_PREFIX, CHAR_MIN - 8'd1);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, UPPER_A);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, UPPER_Z);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, CHAR_MAX + 8'd1);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, 8'h62);
      add_item(ACT_SYMBOL, SYM_MAX + 8'd1);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_SYMBOL, 8'hff);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, 8'h63);
      add_item(ACT_SYMBOL, 8'd3);
      add_item(ACT_PREFIX, 8'h64);
      add_item(ACT_FINISH, 8'd0);
      add_item(ACT_PREFIX, 8'h65);
      add_item(ACT_NONE, 8'h5a);
      add_item(ACT_FINISH, 8'd0);

      // longest prefix, then one char too many, then most symbols plus one
      for (int i = 0; i < PREFIX_LIMIT; i++) add_item(ACT_PREFIX, name_char());
      add_item(ACT_FINISH, 8'($urandom_range(0, 255)));
      for (int i = 0; i <= PREFIX_LIMIT; i++) add_item(ACT_PREFIX, name_char());
      add_item(ACT_FINISH, 8'd0);
      for (int i = 0; i < 3; i++) add_item(ACT_PREFIX, name_char());
      for (int i = 0; i <= TOTAL_LIMIT - 10; i++)
         add_item(ACT_SYMBOL, 8'($urandom_range(0, 31)));
      add_item(ACT_FINISH, 8'd0);

      // random strings, mostly well formed
      short_items = 0;
      while (short_items < 24) begin
         n_pre = $urandom_range(0, 8);
         n_sym = $urandom_range(0, 12);
         noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_pre + n_sym) : -1;
         for (int i = 0; i < n_pre + n_sym; i++) begin
            if (i == noise_at) begin
               add_noise();
               short_items++;
            end
            if (i < n_pre) add_item(ACT_PREFIX, name_char());
            else add_item(ACT_SYMBOL, 8'($urandom_range(0, 31)));
            short_items++;
         end
         add_item(ACT_FINISH, 8'($urandom_range(0, 255)));
         short_items++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request beats forming %0d strings, including max-length and rejected ones",
         items_queued, strings_queued);
      $display("checked %0d response beats, %0d mismatches", beats_checked, errors);
      if (errors == 0 && expected_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
